FILE: rtl/acss_pkg.sv
// Shared types, codes and constants of the ADC channel scan sequencer.
`default_nettype none

package acss_pkg;

    localparam int ACSS_MAX_CHAIN   = 8;
    localparam int ACSS_SAMPLE_BITS = 10;
    localparam int ACSS_LIST_SLOTS  = 8;
    localparam int ACSS_CHAN_W      = 5;

    // request codes
    localparam logic [1:0] REQ_START_SINGLE = 2'd0;
    localparam logic [1:0] REQ_START_CHAIN  = 2'd1;
    localparam logic [1:0] REQ_CONV_DONE    = 2'd2;

    // status codes
    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_DELIVERED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHAIN_LENGTH = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_LIST = 2'd1;
    localparam logic [1:0] CFG_LEFT_ADJUST  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] single_channel;
        logic [9:0] raw_sample;
    } acss_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       start_conversion;
        logic [4:0] convert_channel;
        logic [9:0] sample_value;
        logic [2:0] sample_index;
        logic       sequence_done;
    } acss_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [39:0] data;
    } acss_cfg_item_t;

    typedef struct packed {
        logic [3:0]  chain_length;
        logic [39:0] channel_list;
        logic        left_adjust;
    } acss_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/acss_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
`default_nettype none

interface acss_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/acss_step.sv
// Per-item decision logic: request decode, chain advance and sample alignment.
`default_nettype none

module acss_step
    import acss_pkg::*;
#(
    parameter int MAX_CHAIN = ACSS_MAX_CHAIN,
    parameter int POS_W     = $clog2(MAX_CHAIN + 1)
) (
    input  wire acss_in_t   item,
    input  wire acss_cfg_t  cfg,
    input  wire logic       busy,
    input  wire logic       chain_mode,
    input  wire [POS_W-1:0] position,
    output acss_out_t       result,
    output logic            has_result,
    output logic            busy_next,
    output logic            chain_mode_next,
    output logic [POS_W-1:0] position_next
);

    localparam int CMP_W = (POS_W > 4) ? POS_W : 4;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_CHAIN);

    logic [CMP_W-1:0]       len_raw;
    logic [CMP_W-1:0]       len_eff;
    logic [POS_W-1:0]       pos_inc;
    logic [2:0]             slot_next;
    logic [ACSS_CHAN_W-1:0] entry_first;
    logic [ACSS_CHAN_W-1:0] entry_next;
    logic [9:0]             aligned;

    always_comb
    begin
        len_raw = CMP_W'(cfg.chain_length);
        priority if (len_raw == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (len_raw > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    assign pos_inc     = position + POS_W'(1);
    assign slot_next   = 3'(pos_inc);
    assign entry_first = cfg.channel_list[ACSS_CHAN_W-1:0];
    assign entry_next  = cfg.channel_list[slot_next*ACSS_CHAN_W +: ACSS_CHAN_W];
    // left adjust keeps the top 8 sample bits
    assign aligned     = cfg.left_adjust ? (item.raw_sample >> (ACSS_SAMPLE_BITS - 8))
                                         : item.raw_sample;

    always_comb
    begin
        result          = '0;
        has_result      = 1'b0;
        busy_next       = busy;
        chain_mode_next = chain_mode;
        position_next   = position;
        unique case (item.req_type)
            REQ_START_SINGLE, REQ_START_CHAIN:
            begin
                has_result = 1'b1;
                if (busy)
                begin
                    result.status = ST_BUSY;
                end
                else
                begin
                    result.status           = ST_ACCEPTED;
                    result.start_conversion = 1'b1;
                    busy_next               = 1'b1;
                    if (item.req_type == REQ_START_SINGLE)
                    begin
                        chain_mode_next        = 1'b0;
                        result.convert_channel = item.single_channel;
                    end
                    else
                    begin
                        chain_mode_next        = 1'b1;
                        position_next          = '0;
                        result.convert_channel = entry_first;
                    end
                end
            end
            REQ_CONV_DONE:
            begin
                // drop completions while idle
                if (busy)
                begin
                    has_result          = 1'b1;
                    result.status       = ST_DELIVERED;
                    result.sample_value = aligned;
                    if (!chain_mode)
                    begin
                        result.sequence_done = 1'b1;
                        busy_next            = 1'b0;
                    end
                    else
                    begin
                        result.sample_index = 3'(position);
                        position_next       = pos_inc;
                        if (CMP_W'(pos_inc) >= len_eff)
                        begin
                            result.sequence_done = 1'b1;
                            busy_next            = 1'b0;
                        end
                        else
                        begin
                            result.start_conversion = 1'b1;
                            result.convert_channel  = entry_next;
                        end
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/adc_channel_scan_sequencer.sv
// Top level of the ADC channel scan sequencer.
//
// Channels: "in" takes request items (start single, start chain, conversion
// complete); "out" gives one result item per start request and per completion
// seen while busy; unused codes and idle completions give none. "cfg" writes
// chain_length (index 0), channel_list (index 1) and left_adjust (index 2);
// it is always ready, and writes are meant to happen while the block is idle.
// Path: an accepted item is held in the input register, decided, and
// shown on "out" from the result register.
// Throughput: one item per cycle while "out" is not held; the single result
// register is reloaded in the same cycle it is taken.
// Stall: while "out" is held, the input register keeps its item and in.ready
// drops once it is full; items that give no result still pass through.
// Reset: idle, single mode, position zero, chain_length 1, channel_list 0,
// left_adjust 0; both item registers empty.
`default_nettype none

module adc_channel_scan_sequencer
    import acss_pkg::*;
#(
    parameter int MAX_CHAIN = ACSS_MAX_CHAIN
) (
    input  wire logic clk,
    input  wire logic rst_n,
    acss_stream_if.sink   in,
    acss_stream_if.source out,
    acss_stream_if.sink   cfg
);

    localparam int POS_W = $clog2(MAX_CHAIN + 1);

    acss_cfg_t        cfg_reg;
    logic             in_valid_reg;
    acss_in_t         in_item_reg;
    logic             out_valid_reg;
    acss_out_t        out_item_reg;
    logic             busy_reg;
    logic             chain_mode_reg;
    logic [POS_W-1:0] position_reg;

    acss_out_t        step_result;
    logic             step_has_result;
    logic             busy_next;
    logic             chain_mode_next;
    logic [POS_W-1:0] position_next;
    logic             advance;
    logic             out_free;

    assign out_free  = !out_valid_reg || out.ready;
    assign advance   = in_valid_reg && (out_free || !step_has_result);
    assign in.ready  = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign out.valid   = out_valid_reg;
    assign out.payload = out_item_reg;

    acss_step #(
        .MAX_CHAIN (MAX_CHAIN),
        .POS_W     (POS_W)
    ) u_step (
        .item            (in_item_reg),
        .cfg             (cfg_reg),
        .busy            (busy_reg),
        .chain_mode      (chain_mode_reg),
        .position        (position_reg),
        .result          (step_result),
        .has_result      (step_has_result),
        .busy_next       (busy_next),
        .chain_mode_next (chain_mode_next),
        .position_next   (position_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chain_length <= 4'd1;
            cfg_reg.channel_list <= '0;
            cfg_reg.left_adjust  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                CFG_CHAIN_LENGTH: cfg_reg.chain_length <= cfg.payload.data[3:0];
                CFG_CHANNEL_LIST: cfg_reg.channel_list <= cfg.payload.data;
                CFG_LEFT_ADJUST:  cfg_reg.left_adjust  <= cfg.payload.data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            busy_reg       <= 1'b0;
            chain_mode_reg <= 1'b0;
            position_reg   <= '0;
        end
        else
        begin
            if (in.ready)
            begin
                in_valid_reg <= in.valid;
            end
            if (advance)
            begin
                busy_reg       <= busy_next;
                chain_mode_reg <= chain_mode_next;
                position_reg   <= position_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && step_has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
        begin
            in_item_reg <= in.payload;
        end
        if (advance && step_has_result)
        begin
            out_item_reg <= step_result;
        end
    end

    // a refused start never asks the converter to run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status == ST_BUSY) |-> !out_item_reg.start_conversion)
    else $error("refused start carries a conversion request");

    // the last sample of a sequence never starts another conversion
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.sequence_done) |-> !out_item_reg.start_conversion)
    else $error("sequence end with conversion request");

    // a finished sequence leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_has_result && step_result.sequence_done) |=> !busy_reg)
    else $error("still busy after sequence end");

    // chain position stays within the longest chain
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(position_reg) <= 32'(MAX_CHAIN))
    else $error("chain position out of range");

endmodule

`default_nettype wire
